### src/dade_pkg.sv
// ----------------------------------------------------------------------------
// dade_pkg
// types, register codes and rounding helpers for the debye ade field update
// ----------------------------------------------------------------------------
package dade_pkg;

    localparam int POLE_REGS = 3;
    localparam int AXES      = 3;
    localparam int IN_BITS   = 272;
    localparam int OUT_BITS  = 48;

    typedef enum logic [2:0] {
        REG_CURRENT_COEFF,
        REG_POLE_COUNT,
        REG_DECAY_0,
        REG_DECAY_1,
        REG_DECAY_2,
        REG_DRIVE_0,
        REG_DRIVE_1,
        REG_DRIVE_2
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0]           current_coeff;
        logic [1:0]                   pole_count;
        logic [POLE_REGS-1:0][31:0]   decay;
        logic [POLE_REGS-1:0][31:0]   drive;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{current_coeff: '0, pole_count: 2'd1,
                                   decay: '0, drive: '0};

    typedef struct packed {
        logic signed [31:0] h_b_back;
        logic signed [31:0] h_b_here;
        logic signed [31:0] curl_coeff_b;
        logic signed [31:0] h_a_back;
        logic signed [31:0] h_a_here;
        logic signed [31:0] curl_coeff_a;
        logic signed [31:0] self_coeff;
        logic signed [31:0] e_now;
        logic [11:0]        cell_req;
        logic [1:0]         axis;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] e_new;
        logic [11:0]        cell_out;
        logic [1:0]         axis_out;
    } out_item_t;

    // round half up, drop 24 bits
    function automatic logic signed [40:0] rnd24(input logic signed [64:0] x);
        logic signed [64:0] y;
        y = x + 65'sd8388608;
        return y[64:24];
    endfunction

    // round half up, drop 25 bits
    function automatic logic signed [39:0] rnd25(input logic signed [64:0] x);
        logic signed [64:0] y;
        y = x + 65'sd16777216;
        return y[64:25];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        logic signed [31:0] r;
        if (x > 42'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -42'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

### src/dade_cfg_regs.sv
// ----------------------------------------------------------------------------
// dade_cfg_regs
// configuration register file written through the request channel
// ----------------------------------------------------------------------------
module dade_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output dade_pkg::cfg_t    cfg
);
    import dade_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CURRENT_COEFF: cfg_next.current_coeff = cfg_data;
                REG_POLE_COUNT:    cfg_next.pole_count    = cfg_data[1:0];
                REG_DECAY_0:       cfg_next.decay[0]      = cfg_data;
                REG_DECAY_1:       cfg_next.decay[1]      = cfg_data;
                REG_DECAY_2:       cfg_next.decay[2]      = cfg_data;
                REG_DRIVE_0:       cfg_next.drive[0]      = cfg_data;
                REG_DRIVE_1:       cfg_next.drive[1]      = cfg_data;
                REG_DRIVE_2:       cfg_next.drive[2]      = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

### src/dade_store.sv
// ----------------------------------------------------------------------------
// dade_store
// pole current memory, one bank per pole, swept to zero after reset
// ----------------------------------------------------------------------------
module dade_store #(
    parameter int LANES = 3,
    parameter int DEPTH = 12288
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [LANES-1:0][31:0]        rd_data,
    input  logic [LANES-1:0]              wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [LANES-1:0][31:0]        wr_data,
    output logic                          busy
);
    import dade_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;
    logic          busy_reg;
    logic          busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    assign busy = busy_reg;

    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        logic [31:0] mem [DEPTH];
        logic [31:0] rd_data_reg;

        always_ff @(posedge clk)
        begin
            if (busy_reg)
            begin
                mem[clr_addr_reg] <= '0;
            end
            else if (wr_en[g])
            begin
                mem[wr_addr] <= wr_data[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rd_en)
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end

        assign rd_data[g] = rd_data_reg;
    end

endmodule

### src/dade_datapath.sv
// ----------------------------------------------------------------------------
// dade_datapath
// eight stage update pipeline with elastic stalls and same-cell interlock
// ----------------------------------------------------------------------------
module dade_datapath #(
    parameter int MAX_POLES  = 3,
    parameter int CELL_COUNT = 4096
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  dade_pkg::cfg_t                               cfg,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  dade_pkg::in_item_t                           in_item,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output dade_pkg::out_item_t                          out_item,
    input  logic                                         clr_busy,
    output logic                                         rd_en,
    output logic [$clog2(3*CELL_COUNT)-1:0]              rd_addr,
    input  logic [((MAX_POLES < 3) ? MAX_POLES : 3)-1:0][31:0] rd_data,
    output logic [((MAX_POLES < 3) ? MAX_POLES : 3)-1:0] wr_en,
    output logic [$clog2(3*CELL_COUNT)-1:0]              wr_addr,
    output logic [((MAX_POLES < 3) ? MAX_POLES : 3)-1:0][31:0] wr_data
);
    import dade_pkg::*;

    localparam int NL  = (MAX_POLES < POLE_REGS) ? MAX_POLES : POLE_REGS;
    localparam int AW  = $clog2(AXES * CELL_COUNT);
    localparam int NST = 8;

    typedef struct packed {
        logic [1:0]                   axis;
        logic [11:0]                  cell_idx;
        logic [AW-1:0]                addr;
        logic                         hit;
        logic [1:0]                   np;
        logic signed [31:0]           e_now;
        logic signed [31:0]           c_self;
        logic signed [31:0]           c_a;
        logic signed [31:0]           c_b;
        logic signed [31:0]           h_ah;
        logic signed [31:0]           h_ab;
        logic signed [31:0]           h_bh;
        logic signed [31:0]           h_bb;
        logic signed [31:0]           d_a;
        logic signed [31:0]           d_b;
        logic [POLE_REGS-1:0][64:0]   kp1j;
        logic [POLE_REGS-1:0][64:0]   kj;
        logic signed [64:0]           p_self;
        logic signed [64:0]           p_a;
        logic signed [64:0]           p_b;
        logic signed [31:0]           jsum;
        logic [POLE_REGS-1:0][40:0]   rkj;
        logic signed [33:0]           acc;
        logic signed [64:0]           jprod;
        logic signed [31:0]           jterm;
        logic signed [31:0]           e_new;
        logic signed [31:0]           de;
        logic [POLE_REGS-1:0][64:0]   dp;
    } stage_t;

    stage_t          st_reg  [NST];
    stage_t          st_next [NST];
    logic [NST-1:0]  v_reg;
    logic [NST:0]    en;
    logic            ov_reg;
    out_item_t       out_reg;

    logic            hit_in;
    logic [AW-1:0]   addr_in;
    logic [1:0]      np_in;
    logic            hazard;
    logic            accept;

    // input decode and interlock against in-flight items on the same cell
    always_comb
    begin
        hit_in  = (in_item.axis != 2'd3) && ({20'd0, in_item.cell_req} < 32'(CELL_COUNT));
        addr_in = AW'(in_item.axis) * AW'(CELL_COUNT) + AW'(in_item.cell_req);
        if (!hit_in)
        begin
            np_in = 2'd0;
        end
        else if (32'(cfg.pole_count) > 32'(NL))
        begin
            np_in = 2'(NL);
        end
        else
        begin
            np_in = cfg.pole_count;
        end
        hazard = 1'b0;
        for (int i = 0; i < NST; i++)
        begin
            if (v_reg[i] && st_reg[i].hit && hit_in && (st_reg[i].addr == addr_in))
            begin
                hazard = 1'b1;
            end
        end
    end

    always_comb
    begin
        en[NST] = !ov_reg || out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0] && !clr_busy && !hazard;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_addr  = addr_in;

    // stage 0: capture item, memory read issued
    always_comb
    begin
        st_next[0]          = st_reg[0];
        st_next[0].axis     = in_item.axis;
        st_next[0].cell_idx = in_item.cell_req;
        st_next[0].addr     = addr_in;
        st_next[0].hit      = hit_in;
        st_next[0].np       = np_in;
        st_next[0].e_now    = in_item.e_now;
        st_next[0].c_self   = in_item.self_coeff;
        st_next[0].c_a      = in_item.curl_coeff_a;
        st_next[0].c_b      = in_item.curl_coeff_b;
        st_next[0].h_ah     = in_item.h_a_here;
        st_next[0].h_ab     = in_item.h_a_back;
        st_next[0].h_bh     = in_item.h_b_here;
        st_next[0].h_bb     = in_item.h_b_back;
    end

    // stage 1: h differences, pole products on stored currents
    always_comb
    begin
        logic signed [31:0] j;
        logic signed [31:0] k;
        st_next[1]     = st_reg[0];
        st_next[1].d_a = sat32(42'(st_reg[0].h_ah) - 42'(st_reg[0].h_ab));
        st_next[1].d_b = sat32(42'(st_reg[0].h_bh) - 42'(st_reg[0].h_bb));
        for (int p = 0; p < POLE_REGS; p++)
        begin
            j = (p < NL) ? $signed(rd_data[p]) : 32'sd0;
            k = $signed(cfg.decay[p]);
            st_next[1].kp1j[p] = (65'(k) + 65'sd16777216) * 65'(j);
            st_next[1].kj[p]   = 65'(k) * 65'(j);
        end
    end

    // stage 2: yee products, pole current sum
    always_comb
    begin
        logic signed [41:0] s;
        st_next[2]        = st_reg[1];
        st_next[2].p_self = 65'(st_reg[1].c_self) * 65'(st_reg[1].e_now);
        st_next[2].p_a    = 65'(st_reg[1].c_a) * 65'(st_reg[1].d_a);
        st_next[2].p_b    = 65'(st_reg[1].c_b) * 65'(st_reg[1].d_b);
        s = '0;
        for (int p = 0; p < POLE_REGS; p++)
        begin
            if (p < 32'(st_reg[1].np))
            begin
                s = s + 42'(rnd25($signed(st_reg[1].kp1j[p])));
            end
            st_next[2].rkj[p] = rnd24($signed(st_reg[1].kj[p]));
        end
        st_next[2].jsum = sat32(s);
    end

    // stage 3: yee sum, current term product
    always_comb
    begin
        st_next[3]       = st_reg[2];
        st_next[3].acc   = 34'(sat32(42'(rnd24(st_reg[2].p_self))))
                         + 34'(sat32(42'(rnd24(st_reg[2].p_a))))
                         + 34'(sat32(42'(rnd24(st_reg[2].p_b))));
        st_next[3].jprod = 65'(cfg.current_coeff) * 65'(st_reg[2].jsum);
    end

    // stage 4: current term
    always_comb
    begin
        st_next[4] = st_reg[3];
        if (st_reg[3].np == 2'd0)
        begin
            st_next[4].jterm = '0;
        end
        else
        begin
            st_next[4].jterm = sat32(42'(rnd24(st_reg[3].jprod)));
        end
    end

    // stage 5: new e
    always_comb
    begin
        st_next[5]       = st_reg[4];
        st_next[5].e_new = sat32(42'(st_reg[4].acc) - 42'(st_reg[4].jterm));
    end

    // stage 6: e change
    always_comb
    begin
        st_next[6]    = st_reg[5];
        st_next[6].de = sat32(42'(st_reg[5].e_new) - 42'(st_reg[5].e_now));
    end

    // stage 7: drive products
    always_comb
    begin
        st_next[7] = st_reg[6];
        for (int p = 0; p < POLE_REGS; p++)
        begin
            st_next[7].dp[p] = 65'($signed(cfg.drive[p])) * 65'(st_reg[6].de);
        end
    end

    // current write-back as the item leaves the last stage
    always_comb
    begin
        wr_addr = st_reg[NST-1].addr;
        for (int p = 0; p < NL; p++)
        begin
            wr_en[p]   = en[NST] && v_reg[NST-1] && st_reg[NST-1].hit
                         && (p < 32'(st_reg[NST-1].np));
            wr_data[p] = sat32(42'($signed(st_reg[NST-1].rkj[p]))
                               + 42'(rnd24($signed(st_reg[NST-1].dp[p]))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= accept;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            if (en[NST])
            begin
                ov_reg <= v_reg[NST-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
        if (en[NST])
        begin
            out_reg.axis_out <= st_reg[NST-1].axis;
            out_reg.cell_out <= st_reg[NST-1].cell_idx;
            out_reg.e_new    <= st_reg[NST-1].e_new;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = out_reg;

    a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !in_ready)
        else $error("request accepted during clearing pass");

    a_write_on_retire : assert property (@(posedge clk) disable iff (!rst_n)
        (|wr_en) |-> (en[NST] && v_reg[NST-1] && st_reg[NST-1].hit))
        else $error("current write without a retiring item");

    a_no_poles_on_miss : assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !st_reg[0].hit) |-> (st_reg[0].np == 2'd0))
        else $error("pole count set on an item outside the store");

endmodule

### src/debye_ade_field_update.sv
// ----------------------------------------------------------------------------
// debye_ade_field_update
// debye dispersive fdtd e-field update with auxiliary pole currents
// ----------------------------------------------------------------------------
// One request updates one E component at one cell and returns one result.
// A new request can be taken every cycle unless the output is stalled, the
// memory is being cleared or the same-cell interlock holds it. A request for
// the same axis and cell as one still in the pipeline waits until that one
// has written its pole currents back, since the pole current read and write
// sit at the two ends of the pipeline. After reset the pole current memory
// is cleared one entry per bank per cycle, all 3 * CELL_COUNT entries, while
// s_tready stays low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module debye_ade_field_update #(
    parameter int MAX_POLES  = 3,
    parameter int CELL_COUNT = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // axis, cell_req, e_now, self_coeff, curl_coeff_a, h_a_here, h_a_back,
    // curl_coeff_b, h_b_here, h_b_back, zero fill
    input  logic [271:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // axis_out, cell_out, e_new, zero fill
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import dade_pkg::*;

    localparam int NL    = (MAX_POLES < POLE_REGS) ? MAX_POLES : POLE_REGS;
    localparam int DEPTH = AXES * CELL_COUNT;
    localparam int AW    = $clog2(DEPTH);

    cfg_t                  cfg;
    in_item_t              in_item;
    out_item_t             out_item;
    logic                  clr_busy;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [NL-1:0][31:0]   rd_data;
    logic [NL-1:0]         wr_en;
    logic [AW-1:0]         wr_addr;
    logic [NL-1:0][31:0]   wr_data;

    assign in_item = s_tdata[IN_BITS-3:0];
    assign m_tdata = {2'b00, out_item};

    dade_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dade_store #(
        .LANES (NL),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (clr_busy)
    );

    dade_datapath #(
        .MAX_POLES  (MAX_POLES),
        .CELL_COUNT (CELL_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .clr_busy  (clr_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

endmodule
